### rtl/core/fsgt_pkg.sv
// ---------------------------------------------------------------------------
// fsgt_pkg
// Shared types and codes of the shard group tracker: words, entry, status.
// ---------------------------------------------------------------------------
package fsgt_pkg;

    typedef struct packed {
        logic        operation;
        logic [31:0] seqid;
        logic        is_data;
        logic [10:0] length;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  missing_count;
        logic [19:0] present_mask;
        logic [31:0] group_base;
        logic [10:0] largest_len;
    } t_out_word;

    typedef struct packed {
        logic [31:0] seq;
        logic        data_flag;
        logic [10:0] len;
        logic [31:0] stamp;
    } t_entry;

    localparam logic       OP_ARRIVAL = 1'b0;
    localparam logic       OP_TICK    = 1'b1;

    localparam logic [2:0] ST_COMPLETE    = 3'd0;
    localparam logic [2:0] ST_RECOVERABLE = 3'd1;
    localparam logic [2:0] ST_INCOMPLETE  = 3'd2;
    localparam logic [2:0] ST_DUPLICATE   = 3'd3;
    localparam logic [2:0] ST_TICK        = 3'd4;

    localparam logic [1:0] CFG_DATA_SHARDS   = 2'd0;
    localparam logic [1:0] CFG_PARITY_SHARDS = 2'd1;
    localparam logic [1:0] CFG_EXPIRE_TICKS  = 2'd2;
    localparam logic [1:0] CFG_RX_LIMIT      = 2'd3;

endpackage

### rtl/core/fec_shard_group_tracker_core.sv
// ---------------------------------------------------------------------------
// fec_shard_group_tracker_core
// Sorted store of shard headers with group gathering, freeing and expiry.
// ---------------------------------------------------------------------------
// channel   | handshake                    | payload
// ----------+------------------------------+-------------------------------
// command   | i_start, o_busy              | i_in  (t_in_word)
// result    | o_valid (one-cycle strobe)   | o_out (t_out_word)
// config    | i_cfg_valid, o_cfg_ready     | i_cfg_index, i_cfg_data
//
// A tick word's result shows on the next cycle and the block is free again
// at once. An arrival word first runs a bit-serial remainder division, then
// one pass over the store per phase (optional expiry sweep, scan, then any
// free / shift pass). Each pass reads the store through the single registered
// read port, and a shift pass ends with a write of the new entry.
// Reset is synchronous, active low; the store needs no clearing pass since
// only entries below the fill count are read. The result receiver cannot
// stall; the result word appears when the scan ends, while a following free
// or shift pass, if any, still runs with o_busy high.
// ---------------------------------------------------------------------------
module fec_shard_group_tracker_core #(
    parameter int CAPACITY   = 64,
    parameter int MAX_LEN    = 2048,
    parameter int MAX_DATA   = 16,
    parameter int MAX_PARITY = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  fsgt_pkg::t_in_word  i_in,
    output logic                o_valid,
    output fsgt_pkg::t_out_word o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [13:0]         i_cfg_data
);
    import fsgt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_SWEEP, S_SCAN, S_FREE, S_SHDN, S_SHUP, S_WNEW
    } t_state;

    // entry store: one write port, one registered read port
    t_entry r_mem [CAPACITY];
    t_entry r_q;
    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic [AW-1:0]   mem_ra;
    t_entry          mem_wd;

    t_state      r_state;
    t_in_word    r_item;
    logic [10:0] r_len;
    logic [CW-1:0] r_cnt, r_rd, r_pidx, r_w, r_pos;
    logic        r_pv;
    logic [31:0] r_now, r_last, r_base;
    logic [4:0]  r_dsh;
    logic [2:0]  r_psh;
    logic [13:0] r_exp;
    logic [6:0]  r_lim;
    logic [4:0]  r_rem, r_dcnt;
    logic        r_dup, r_evict, r_first, r_grow;
    logic [4:0]  r_nall, r_ndata;
    logic [10:0] r_bs;
    logic [19:0] r_mask;
    logic        r_ov;
    t_out_word   r_out;

    logic [4:0]  dsat, total;
    logic [2:0]  psat;
    logic [31:0] lim32;
    logic [10:0] len_sat;
    logic [5:0]  div_t;
    logic [4:0]  rem_next;
    logic        issue;
    logic [CW-1:0] rd_idx;
    logic        keep_exp, in_grp, is_less, is_eq;
    logic [31:0] q_off;
    logic [4:0]  fin_nall, fin_ndata;
    logic [10:0] fin_bs;
    logic [19:0] fin_mask;
    logic [2:0]  fin_status;
    logic [4:0]  fin_missing;

    assign o_busy      = (r_state != S_IDLE);
    assign o_valid     = r_ov;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    // clamp shard counts, the entry limit and the shard length
    always_comb begin
        if (r_dsh == 5'd0)                 dsat = 5'd1;
        else if (32'(r_dsh) > MAX_DATA)    dsat = 5'(MAX_DATA);
        else                               dsat = r_dsh;
        if (r_psh == 3'd0)                 psat = 3'd1;
        else if (32'(r_psh) > MAX_PARITY)  psat = 3'(MAX_PARITY);
        else                               psat = r_psh;
        total = dsat + 5'(psat);
        lim32 = (32'(r_lim) < 32'(CAPACITY - 1)) ? 32'(r_lim) : 32'(CAPACITY - 1);
        len_sat = (32'(i_in.length) > 32'(MAX_LEN - 1)) ? 11'(MAX_LEN - 1) : i_in.length;
    end

    // one quotient bit a cycle, keep only the remainder
    always_comb begin
        div_t    = {r_rem, r_item.seqid[5'd31 - r_dcnt]};
        rem_next = (div_t >= 6'(total)) ? 5'(div_t - 6'(total)) : div_t[4:0];
    end

    // entry tests on the word just read
    always_comb begin
        q_off    = r_q.seq - r_base;
        keep_exp = ((r_now - r_q.stamp) <= 32'(r_exp));
        in_grp   = (r_q.seq >= r_base) && (q_off < 32'(total));
        is_less  = (r_q.seq < r_item.seqid);
        is_eq    = (r_q.seq == r_item.seqid);
    end

    // group summary including the arriving shard
    always_comb begin
        fin_nall  = r_nall + 5'd1;
        fin_ndata = r_ndata + 5'(r_item.is_data);
        fin_bs    = (r_len > r_bs) ? r_len : r_bs;
        fin_mask  = r_mask | (20'd1 << r_rem);
        fin_missing = 5'd0;
        if (fin_ndata >= dsat) begin
            fin_status = ST_COMPLETE;
        end else if (fin_nall >= dsat) begin
            fin_status  = ST_RECOVERABLE;
            fin_missing = dsat - fin_ndata;
        end else begin
            fin_status = ST_INCOMPLETE;
        end
    end

    // memory port steering per pass
    always_comb begin
        issue  = 1'b0;
        rd_idx = r_rd;
        mem_we = 1'b0;
        mem_wa = r_w[AW-1:0];
        mem_wd = r_q;
        case (r_state)
            S_SWEEP: begin
                issue  = (r_rd < r_cnt);
                mem_we = r_pv && keep_exp;
            end
            S_SCAN: begin
                issue = (r_rd < r_cnt);
            end
            S_FREE: begin
                issue  = (r_rd < r_cnt);
                mem_we = r_pv && !in_grp && !(r_evict && !r_first);
            end
            S_SHDN: begin
                issue  = (r_rd < r_pos);
                mem_we = r_pv;
                mem_wa = AW'(r_pidx - CW'(1));
            end
            S_SHUP: begin
                issue  = (r_rd > r_pos);
                rd_idx = r_rd - CW'(1);
                mem_we = r_pv;
                mem_wa = AW'(r_pidx + CW'(1));
            end
            S_WNEW: begin
                mem_we = 1'b1;
                mem_wd = '{seq: r_item.seqid, data_flag: r_item.is_data,
                           len: r_len, stamp: r_now};
            end
            default: ;
        endcase
        mem_ra = rd_idx[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_q <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_now   <= '0;
            r_last  <= '0;
            r_dsh   <= 5'd4;
            r_psh   <= 3'd2;
            r_exp   <= 14'd1000;
            r_lim   <= 7'd48;
            r_ov    <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_ov <= 1'b0;

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_DATA_SHARDS:   r_dsh <= i_cfg_data[4:0];
                    CFG_PARITY_SHARDS: r_psh <= i_cfg_data[2:0];
                    CFG_EXPIRE_TICKS:  r_exp <= i_cfg_data;
                    CFG_RX_LIMIT:      r_lim <= i_cfg_data[6:0];
                    default: ;
                endcase
            end

            // read pipeline of every pass
            r_pv <= issue;
            if (issue) begin
                r_pidx <= rd_idx;
                if (r_state == S_SHUP) r_rd <= r_rd - CW'(1);
                else                   r_rd <= r_rd + CW'(1);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        if (i_in.operation == OP_TICK) begin
                            r_now <= r_now + 32'd1;
                            r_ov  <= 1'b1;
                            r_out <= '{status: ST_TICK, default: '0};
                        end else begin
                            r_item  <= i_in;
                            r_len   <= len_sat;
                            r_rem   <= '0;
                            r_dcnt  <= '0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem  <= rem_next;
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == 5'd31) begin
                        r_base  <= r_item.seqid - 32'(rem_next);
                        r_rd    <= '0;
                        r_w     <= '0;
                        r_pos   <= '0;
                        r_dup   <= 1'b0;
                        r_nall  <= '0;
                        r_ndata <= '0;
                        r_bs    <= '0;
                        r_mask  <= '0;
                        r_state <= ((r_now - r_last) >= 32'(r_exp)) ? S_SWEEP : S_SCAN;
                    end
                end
                S_SWEEP: begin
                    if (r_pv && keep_exp) r_w <= r_w + CW'(1);
                    if (!issue && !r_pv) begin
                        r_cnt   <= r_w;
                        r_last  <= r_now;
                        r_rd    <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_pv) begin
                        if (is_less) r_pos <= r_pos + CW'(1);
                        if (is_eq)   r_dup <= 1'b1;
                        if (in_grp) begin
                            r_nall  <= r_nall + 5'd1;
                            r_ndata <= r_ndata + 5'(r_q.data_flag);
                            if (r_q.len > r_bs) r_bs <= r_q.len;
                            r_mask  <= r_mask | (20'd1 << q_off[4:0]);
                        end
                    end
                    if (!issue && !r_pv) begin
                        r_ov <= 1'b1;
                        r_first <= 1'b0;
                        if (r_dup) begin
                            r_out   <= '{status: ST_DUPLICATE, default: '0};
                            r_state <= S_IDLE;
                        end else begin
                            r_out <= '{status: fin_status, missing_count: fin_missing,
                                       present_mask: fin_mask, group_base: r_base,
                                       largest_len: fin_bs};
                            if (fin_status != ST_INCOMPLETE) begin
                                // free the group; the new shard is never stored
                                r_evict <= (32'(r_cnt - CW'(r_nall)) > lim32);
                                r_rd    <= '0;
                                r_w     <= '0;
                                r_state <= S_FREE;
                            end else if (32'(r_cnt) + 32'd1 > lim32) begin
                                // insert then drop the lowest: shift the lower part down
                                r_grow <= 1'b0;
                                r_rd   <= CW'(1);
                                r_w    <= r_pos - CW'(1);
                                r_state <= (r_pos == '0) ? S_IDLE : S_SHDN;
                            end else begin
                                r_grow  <= 1'b1;
                                r_rd    <= r_cnt;
                                r_w     <= r_pos;
                                r_state <= S_SHUP;
                            end
                        end
                    end
                end
                S_FREE: begin
                    if (r_pv && !in_grp) begin
                        if (r_evict && !r_first) r_first <= 1'b1;
                        else                     r_w <= r_w + CW'(1);
                    end
                    if (!issue && !r_pv) begin
                        r_cnt   <= r_w;
                        r_state <= S_IDLE;
                    end
                end
                S_SHDN, S_SHUP: begin
                    if (!issue && !r_pv) r_state <= S_WNEW;
                end
                S_WNEW: begin
                    if (r_grow) r_cnt <= r_cnt + CW'(1);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### rtl/core/fsgt_checker.sv
// ---------------------------------------------------------------------------
// fsgt_checker
// Port-level checks of the shard group tracker, bound to the top level.
// ---------------------------------------------------------------------------
module fsgt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_start,
    input logic                o_busy,
    input fsgt_pkg::t_in_word  i_in,
    input logic                o_valid,
    input fsgt_pkg::t_out_word o_out
);
    import fsgt_pkg::*;

    a_tick_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_in.operation == OP_TICK)
            |=> (o_valid && o_out.status == ST_TICK))
        else $error("tick word not acknowledged next cycle");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(o_busy) || $past(i_start)))
        else $error("result word without a command");

    a_dup_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.status == ST_DUPLICATE)
            |-> (o_out.present_mask == '0 && o_out.group_base == '0))
        else $error("duplicate word carries group data");

    a_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_out.status == ST_COMPLETE || o_out.status == ST_INCOMPLETE))
            |-> (o_out.missing_count == '0))
        else $error("missing count set without recovery");

    a_recov: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out.status == ST_RECOVERABLE) |-> (o_out.missing_count != '0))
        else $error("recoverable group with nothing missing");

endmodule

bind fec_shard_group_tracker_core fsgt_checker u_fsgt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .i_in    (i_in),
    .o_valid (o_valid),
    .o_out   (o_out)
);

### verif/fec_shard_group_tracker_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// fec_shard_group_tracker_core_tb
// Drives arrival and tick words into the shard group tracker across several
// register settings. A shadow store predicts every result word, and each
// strobed result is compared field by field in arrival order.
// ---------------------------------------------------------------------------
module fec_shard_group_tracker_core_tb;
    import fsgt_pkg::*;

    localparam int CAP        = 64;
    localparam int LEN_TOP    = 2047;
    localparam int DATA_TOP   = 16;
    localparam int PARITY_TOP = 4;
    localparam int CYCLE_LIMIT = 4000000;

    // Shadow of the shard store plus the expected result words.
    class shard_group_scoreboard;
        logic [4:0]  data_shards   = 5'd4;
        logic [2:0]  parity_shards = 3'd2;
        logic [13:0] expire_ticks  = 14'd1000;
        logic [6:0]  rx_limit      = 7'd48;
        t_entry      store[CAP];
        int          fill = 0;
        logic [31:0] now_time = 0;
        logic [31:0] last_sweep = 0;
        t_out_word   pending_words[$];
        int          mismatches = 0;

        function void write_reg(logic [1:0] idx, logic [13:0] value);
            case (idx)
                CFG_DATA_SHARDS:   data_shards   = value[4:0];
                CFG_PARITY_SHARDS: parity_shards = value[2:0];
                CFG_EXPIRE_TICKS:  expire_ticks  = value;
                default:           rx_limit      = value[6:0];
            endcase
        endfunction

        task report(string what);
            $display("MISMATCH: %s", what);
            mismatches++;
        endtask

        // Keep entries that survive; mode 0 drops stale ones, else the group.
        function void squeeze(bit by_group, longint unsigned base, longint unsigned total);
            int w;
            bit drop;
            longint unsigned s;
            w = 0;
            for (int r = 0; r < fill; r++) begin
                s = store[r].seq;
                if (!by_group) drop = (now_time - store[r].stamp) > {18'd0, expire_ticks};
                else drop = (s >= base) && (s - base < total);
                if (!drop) begin
                    store[w] = store[r];
                    w++;
                end
            end
            fill = w;
        endfunction

        function void note_word(t_in_word w);
            t_out_word       res;
            int              pos, lim, d, p, nall, ndata;
            longint unsigned base, total, s;
            res = '0;
            if (w.operation == OP_TICK) begin
                now_time++;
                res.status = ST_TICK;
                pending_words.push_back(res);
                return;
            end
            if ((now_time - last_sweep) >= {18'd0, expire_ticks}) begin
                squeeze(0, 0, 0);
                last_sweep = now_time;
            end
            pos = 0;
            while (pos < fill && store[pos].seq < w.seqid) pos++;
            if (pos < fill && store[pos].seq == w.seqid) begin
                res.status = ST_DUPLICATE;
                pending_words.push_back(res);
                return;
            end
            lim = (rx_limit < CAP - 1) ? rx_limit : CAP - 1;
            for (int j = fill; j > pos; j--) store[j] = store[j-1];
            store[pos].seq       = w.seqid;
            store[pos].data_flag = w.is_data;
            store[pos].len       = w.length;
            store[pos].stamp     = now_time;
            fill++;
            d = (data_shards < 1) ? 1 : ((data_shards > DATA_TOP) ? DATA_TOP : data_shards);
            p = (parity_shards < 1) ? 1 :
                ((parity_shards > PARITY_TOP) ? PARITY_TOP : parity_shards);
            total = d + p;
            base = w.seqid - (w.seqid % total);
            nall = 0;
            ndata = 0;
            for (int j = 0; j < fill; j++) begin
                s = store[j].seq;
                if (s >= base && s - base < total) begin
                    res.present_mask[s - base] = 1'b1;
                    nall++;
                    if (store[j].data_flag) ndata++;
                    if (store[j].len > res.largest_len) res.largest_len = store[j].len;
                end
            end
            if (ndata >= d) begin
                res.status = ST_COMPLETE;
            end else if (nall >= d) begin
                res.status = ST_RECOVERABLE;
                res.missing_count = 5'(d - ndata);
            end else begin
                res.status = ST_INCOMPLETE;
            end
            if (res.status != ST_INCOMPLETE) squeeze(1, base, total);
            // Evict the lowest seqid, at most one per arrival.
            if (fill > lim && fill > 0) begin
                for (int j = 1; j < fill; j++) store[j-1] = store[j];
                fill--;
            end
            res.group_base = base[31:0];
            pending_words.push_back(res);
        endfunction

        task check_word(t_out_word got);
            t_out_word exp_w;
            if (pending_words.size() == 0) begin
                report($sformatf("unexpected result word status %0d", got.status));
                return;
            end
            exp_w = pending_words.pop_front();
            if (got.status !== exp_w.status)
                report($sformatf("status %0d, want %0d", got.status, exp_w.status));
            if (got.missing_count !== exp_w.missing_count)
                report($sformatf("missing_count %0d, want %0d",
                                 got.missing_count, exp_w.missing_count));
            if (got.present_mask !== exp_w.present_mask)
                report($sformatf("present_mask %h, want %h",
                                 got.present_mask, exp_w.present_mask));
            if (got.group_base !== exp_w.group_base)
                report($sformatf("group_base %h, want %h", got.group_base, exp_w.group_base));
            if (got.largest_len !== exp_w.largest_len)
                report($sformatf("largest_len %0d, want %0d",
                                 got.largest_len, exp_w.largest_len));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    t_in_word    i_in = '0;
    logic        o_valid;
    t_out_word   o_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [13:0] i_cfg_data = '0;

    shard_group_scoreboard sb = new();
    int cycle_count = 0;

    fec_shard_group_tracker_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Abort on a hang.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Results cannot be held off: take every strobed word.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_word(o_out);
    end

    // Mostly short gaps, a few long ones, and runs with none.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Present one word; start stays high if the next word follows at once.
    task automatic send_word(t_in_word w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in    <= w;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        sb.note_word(w);
    endtask

    task automatic arrive(logic [31:0] seq, logic isd, logic [10:0] len);
        t_in_word w;
        w.operation = OP_ARRIVAL;
        w.seqid     = seq;
        w.is_data   = isd;
        w.length    = len;
        send_word(w);
    endtask

    task automatic tick();
        t_in_word w;
        w.operation = OP_TICK;
        w.seqid     = $urandom;
        w.is_data   = 1'($urandom_range(0, 1));
        w.length    = 11'($urandom_range(0, LEN_TOP));
        send_word(w);
    endtask

    // Hold until drained and idle, then write one register.
    task automatic write_reg(logic [1:0] idx, logic [13:0] value);
        i_start <= 1'b0;
        while (sb.pending_words.size() != 0) @(posedge i_clk);
        do @(posedge i_clk); while (o_busy);
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, value);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_all(int d, int p, int e, int l);
        write_reg(CFG_DATA_SHARDS, 14'(d));
        write_reg(CFG_PARITY_SHARDS, 14'(p));
        write_reg(CFG_EXPIRE_TICKS, 14'(e));
        write_reg(CFG_RX_LIMIT, 14'(l));
    endtask

    // Well-formed bursts around one group region, with ticks and noise mixed in.
    task automatic random_phase(int n_items);
        logic [31:0] region;
        int done, burst, r;
        done = 0;
        while (done < n_items) begin
            r = $urandom_range(0, 9);
            if (r == 0) region = 32'hFFFF_FFFF - $urandom_range(0, 40);
            else if (r < 4) region = $urandom_range(0, 200);
            else region = $urandom;
            burst = $urandom_range(3, 24);
            for (int k = 0; k < burst; k++) begin
                r = $urandom_range(0, 99);
                if (r < 12) tick();
                else if (r < 16) arrive($urandom, 1'($urandom_range(0, 1)),
                                        11'($urandom_range(0, LEN_TOP)));
                else arrive(region + $urandom_range(0, 24), $urandom_range(0, 3) != 0,
                            ($urandom_range(0, 9) == 0) ? 11'(LEN_TOP) :
                                                          11'($urandom_range(0, LEN_TOP)));
                done++;
            end
            // Now and then let time run to reach the expiry sweep.
            if ($urandom_range(0, 7) == 0) begin
                burst = $urandom_range(10, 45);
                for (int k = 0; k < burst; k++) tick();
                done += burst;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, group of six starting at zero.
        arrive(32'd0, 1'b1, 11'd0);
        arrive(32'd0, 1'b0, 11'd5);          // duplicate
        arrive(32'd1, 1'b1, 11'(LEN_TOP));
        arrive(32'd4, 1'b0, 11'd100);
        arrive(32'd2, 1'b1, 11'd7);          // recoverable, one missing
        arrive(32'd6, 1'b1, 11'd1);
        arrive(32'd7, 1'b1, 11'd2);
        arrive(32'd8, 1'b1, 11'd3);
        arrive(32'd9, 1'b1, 11'd4);          // complete
        arrive(32'hFFFF_FFFF, 1'b1, 11'd9);  // short last group
        arrive(32'hFFFF_FFFE, 1'b0, 11'(LEN_TOP));
        tick();
        tick();
        // Saturated counts, tiny limit, fast expiry.
        set_all(0, 0, 30, 0);
        arrive(32'd10, 1'b1, 11'd1);
        arrive(32'd11, 1'b0, 11'd2);
        for (int k = 0; k < 31; k++) tick();
        arrive(32'd20, 1'b0, 11'd3);
        set_all(31, 7, 16383, 127);
        arrive(32'd100, 1'b1, 11'd4);
        arrive(32'd101, 1'b0, 11'd5);

        set_all(4, 2, 1000, 48);
        random_phase(240);
        set_all(1, 1, 30, 2);
        random_phase(240);
        set_all(16, 4, 10000, 64);
        random_phase(240);
        set_all(31, 7, 16383, 127);
        random_phase(200);
        set_all(0, 0, 30, 0);
        random_phase(200);
        set_all($urandom_range(1, 16), $urandom_range(1, 4),
                $urandom_range(30, 200), $urandom_range(2, 20));
        random_phase(260);

        i_start <= 1'b0;
        while (sb.pending_words.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

### fec_shard_group_tracker_core.f
rtl/core/fsgt_pkg.sv
rtl/core/fec_shard_group_tracker_core.sv
rtl/core/fsgt_checker.sv
verif/fec_shard_group_tracker_core_tb.sv
